// ----- sv/lru_cache_line_controller_assert.svh -----
// ----------------------------------------------------------------------------
// lru_cache_line_controller_assert.svh
// Assertion macros for the cache line controller; empty under synthesis
// ----------------------------------------------------------------------------
`ifndef LRU_CACHE_LINE_CONTROLLER_ASSERT_SVH
`define LRU_CACHE_LINE_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
// checked property, off while reset is applied
`define LCC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// checked property, also live during reset
`define LCC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define LCC_ASSERT(name, prop, msg)
`define LCC_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ----- sv/lcc_pkg.sv -----
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared widths, constants, types and helpers of the cache line controller
// ----------------------------------------------------------------------------
package lcc_pkg;

  // field widths
  localparam int ADDR_W  = 7;
  localparam int LINE_W  = 4;
  localparam int OFS_W   = 4;
  localparam int WORDS_W = 4;
  localparam int SLOT_W  = 4;
  localparam int STALL_W = 8;

  // memory geometry
  localparam int LINE_WORDS = 10;
  localparam int MEM_TOP    = 127;
  localparam int LAST_LINE  = MEM_TOP / LINE_WORDS;
  localparam int LAST_WORDS = MEM_TOP + 1 - LAST_LINE * LINE_WORDS;

  // divide by LINE_WORDS as multiply and shift, exact over the address range
  localparam int RECIP_W    = 8;
  localparam int LINE_RECIP = 205;
  localparam int LINE_SHIFT = 11;

  localparam logic [STALL_W-1:0] MISS_PENALTY_RST = STALL_W'(10);

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  // outcome of one table lookup
  typedef struct packed {
    logic              hit;
    logic              writeback;
    logic [SLOT_W-1:0] slot;
    logic [LINE_W-1:0] victim_line;
  } lkp_res_t;

  // words held by a line: the last line is short
  function automatic logic [WORDS_W-1:0] line_words(input logic [LINE_W-1:0] lnum);
    if (lnum == LINE_W'(LAST_LINE)) begin
      return WORDS_W'(LAST_WORDS);
    end
    return WORDS_W'(LINE_WORDS);
  endfunction

endpackage

// ----- sv/lru_cache_line_controller.sv -----
// ----------------------------------------------------------------------------
// lru_cache_line_controller
// Fully associative LRU line controller: per word address it reports hit or
// miss, the slot used, write-back of a victim, fill size and stall charge
// ----------------------------------------------------------------------------
//  channel  | ports                               | transfer
//  ---------+-------------------------------------+---------------------------
//  input    | start, busy, in_address             | start high while busy low
//  result   | out_strobe, out_*                   | out_strobe, one cycle
//  config   | cfg_valid, cfg_ready, cfg_miss_pen. | valid and ready both high
//
//  an item is a registered table read from the row memory, then the lookup
//  and write-back of the row; a new item is not taken until that
//  write-back has landed, so the next read sees the updated row
//  the result shows in the cycle after the lookup, while the next item is taken
//  after reset a clearing pass zeroes the table while busy stays high
//  the result side has no stall; cfg_ready is always high
// ----------------------------------------------------------------------------
`include "lru_cache_line_controller_assert.svh"

module lru_cache_line_controller #(
  parameter int LINES = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          start,
  output logic                          busy,
  input  logic [lcc_pkg::ADDR_W-1:0]    in_address,
  // result channel
  output logic                          out_strobe,
  output logic                          out_hit,
  output logic [lcc_pkg::SLOT_W-1:0]    out_line_slot,
  output logic [lcc_pkg::OFS_W-1:0]     out_word_offset,
  output logic [lcc_pkg::ADDR_W-1:0]    out_line_base,
  output logic                          out_writeback,
  output logic [lcc_pkg::ADDR_W-1:0]    out_victim_base,
  output logic [lcc_pkg::WORDS_W-1:0]   out_writeback_words,
  output logic [lcc_pkg::WORDS_W-1:0]   out_fill_words,
  output logic [lcc_pkg::STALL_W-1:0]   out_stall_cycles,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lcc_pkg::STALL_W-1:0]   cfg_miss_penalty
);
  import lcc_pkg::*;

  localparam int RANK_W = (LINES > 1) ? $clog2(LINES) : 1;

  state_t state_r;
  state_t state_nxt;

  logic                  accept;
  logic [STALL_W-1:0]    miss_penalty_r;
  logic [ADDR_W-1:0]     sat_address;
  logic [LINE_W-1:0]     line_num;
  logic [ADDR_W-1:0]     addr_r;
  logic [LINE_W-1:0]     line_r;

  logic                  wr_en;
  logic [LINES-1:0]             wr_valid;
  logic [LINES-1:0][LINE_W-1:0] wr_line;
  logic [LINES-1:0][RANK_W-1:0] wr_rank;
  logic [LINES-1:0]             rd_valid;
  logic [LINES-1:0][LINE_W-1:0] rd_line;
  logic [LINES-1:0][RANK_W-1:0] rd_rank;
  logic [LINES-1:0]             upd_valid;
  logic [LINES-1:0][LINE_W-1:0] upd_line;
  logic [LINES-1:0][RANK_W-1:0] upd_rank;
  lkp_res_t              lkp;

  logic [ADDR_W-1:0]     base;
  logic                  out_strobe_r;
  logic                  out_hit_r;
  logic [SLOT_W-1:0]     out_line_slot_r;
  logic [OFS_W-1:0]      out_word_offset_r;
  logic [ADDR_W-1:0]     out_line_base_r;
  logic                  out_writeback_r;
  logic [ADDR_W-1:0]     out_victim_base_r;
  logic [WORDS_W-1:0]    out_writeback_words_r;
  logic [WORDS_W-1:0]    out_fill_words_r;
  logic [STALL_W-1:0]    out_stall_cycles_r;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // miss penalty register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_penalty_r <= MISS_PENALTY_RST;
    end else if (cfg_valid && cfg_ready) begin
      miss_penalty_r <= cfg_miss_penalty;
    end
  end

  // address split and capture
  lcc_addr_split u_split (
    .address     (in_address),
    .sat_address (sat_address),
    .line_num    (line_num)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= sat_address;
      line_r <= line_num;
    end
  end

  // table memory: zero row on clear, updated row after lookup
  assign wr_en    = (state_r == ST_CLEAR) || (state_r == ST_LOOK);
  assign wr_valid = (state_r == ST_LOOK) ? upd_valid : '0;
  assign wr_line  = (state_r == ST_LOOK) ? upd_line  : '0;
  assign wr_rank  = (state_r == ST_LOOK) ? upd_rank  : '0;

  lcc_tag_store #(.LINES(LINES)) u_store (
    .clk      (clk),
    .rd_en    (accept),
    .wr_en    (wr_en),
    .wr_valid (wr_valid),
    .wr_line  (wr_line),
    .wr_rank  (wr_rank),
    .rd_valid (rd_valid),
    .rd_line  (rd_line),
    .rd_rank  (rd_rank)
  );

  lcc_lru_lookup #(.LINES(LINES)) u_lookup (
    .cur_valid (rd_valid),
    .cur_line  (rd_line),
    .cur_rank  (rd_rank),
    .req_line  (line_r),
    .res       (lkp),
    .new_valid (upd_valid),
    .new_line  (upd_line),
    .new_rank  (upd_rank)
  );

  // line base of the request
  assign base = ADDR_W'(line_r * LINE_WORDS);

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (state_r == ST_LOOK);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state_r == ST_LOOK) begin
      out_hit_r         <= lkp.hit;
      out_line_slot_r   <= lkp.slot;
      out_word_offset_r <= OFS_W'(addr_r - base);
      out_line_base_r   <= base;
      out_writeback_r   <= lkp.writeback;
      out_victim_base_r <= lkp.writeback ? ADDR_W'(lkp.victim_line * LINE_WORDS) : '0;
      out_writeback_words_r <= lkp.writeback ? line_words(lkp.victim_line) : '0;
      out_fill_words_r      <= lkp.hit ? '0 : line_words(line_r);
      out_stall_cycles_r    <= lkp.hit ? '0 : miss_penalty_r;
    end
  end

  assign out_strobe          = out_strobe_r;
  assign out_hit             = out_hit_r;
  assign out_line_slot       = out_line_slot_r;
  assign out_word_offset     = out_word_offset_r;
  assign out_line_base       = out_line_base_r;
  assign out_writeback       = out_writeback_r;
  assign out_victim_base     = out_victim_base_r;
  assign out_writeback_words = out_writeback_words_r;
  assign out_fill_words      = out_fill_words_r;
  assign out_stall_cycles    = out_stall_cycles_r;

  // checks
  `LCC_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> busy, "not busy after reset")
  `LCC_ASSERT(a_item_result, accept |-> ##2 out_strobe, "item without result")
  `LCC_ASSERT(a_strobe_src, out_strobe |-> $past(state_r) == ST_LOOK, "stray result strobe")
  `LCC_ASSERT(a_hit_quiet, out_strobe && out_hit |-> !out_writeback && (out_fill_words == '0) && (out_stall_cycles == '0), "hit with miss fields")
  `LCC_ASSERT(a_wb_words, out_strobe && out_writeback |-> !out_hit && (out_writeback_words != '0), "write-back without words")

endmodule

// ----- sv/lcc_addr_split.sv -----
// ----------------------------------------------------------------------------
// lcc_addr_split
// Clamps a word address to the memory and derives its line number
// ----------------------------------------------------------------------------
module lcc_addr_split (
  input  logic [lcc_pkg::ADDR_W-1:0] address,
  output logic [lcc_pkg::ADDR_W-1:0] sat_address,
  output logic [lcc_pkg::LINE_W-1:0] line_num
);
  import lcc_pkg::*;

  localparam int PROD_W = ADDR_W + RECIP_W;

  logic [PROD_W-1:0] prod;

  // clamp to the top of memory
  assign sat_address = (address > ADDR_W'(MEM_TOP)) ? ADDR_W'(MEM_TOP) : address;

  // line number by reciprocal multiply
  assign prod     = PROD_W'(sat_address) * PROD_W'(LINE_RECIP);
  assign line_num = prod[LINE_SHIFT +: LINE_W];

endmodule

// ----- sv/lcc_tag_store.sv -----
// ----------------------------------------------------------------------------
// lcc_tag_store
// Synchronous table memory: one row with valid, line and rank of every slot
// ----------------------------------------------------------------------------
module lcc_tag_store #(
  parameter  int LINES  = 5,
  localparam int RANK_W = (LINES > 1) ? $clog2(LINES) : 1
) (
  input  logic                                  clk,
  input  logic                                  rd_en,
  input  logic                                  wr_en,
  input  logic [LINES-1:0]                      wr_valid,
  input  logic [LINES-1:0][lcc_pkg::LINE_W-1:0] wr_line,
  input  logic [LINES-1:0][RANK_W-1:0]          wr_rank,
  output logic [LINES-1:0]                      rd_valid,
  output logic [LINES-1:0][lcc_pkg::LINE_W-1:0] rd_line,
  output logic [LINES-1:0][RANK_W-1:0]          rd_rank
);
  import lcc_pkg::*;

  localparam int ROW_W = LINES * (1 + LINE_W + RANK_W);

  logic [ROW_W-1:0] mem_r [1];
  logic [ROW_W-1:0] rd_row_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[0] <= {wr_valid, wr_line, wr_rank};
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= mem_r[0];
    end
  end

  assign {rd_valid, rd_line, rd_rank} = rd_row_r;

endmodule

// ----- sv/lcc_lru_lookup.sv -----
// ----------------------------------------------------------------------------
// lcc_lru_lookup
// Tag match, victim choice and LRU rank update over one table row
// ----------------------------------------------------------------------------
module lcc_lru_lookup #(
  parameter  int LINES  = 5,
  localparam int RANK_W = (LINES > 1) ? $clog2(LINES) : 1
) (
  input  logic [LINES-1:0]                      cur_valid,
  input  logic [LINES-1:0][lcc_pkg::LINE_W-1:0] cur_line,
  input  logic [LINES-1:0][RANK_W-1:0]          cur_rank,
  input  logic [lcc_pkg::LINE_W-1:0]            req_line,
  output lcc_pkg::lkp_res_t                     res,
  output logic [LINES-1:0]                      new_valid,
  output logic [LINES-1:0][lcc_pkg::LINE_W-1:0] new_line,
  output logic [LINES-1:0][RANK_W-1:0]          new_rank
);
  import lcc_pkg::*;

  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic              has_free;
  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] lru_slot;
  logic [SLOT_W-1:0] slot;
  logic [RANK_W-1:0] old_rank;
  logic [LINE_W-1:0] victim_line;
  logic              victim_valid;

  // priority scans, lowest slot wins
  always_comb begin
    hit       = 1'b0;
    hit_slot  = '0;
    has_free  = 1'b0;
    free_slot = '0;
    lru_slot  = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (cur_valid[i] && (cur_line[i] == req_line)) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
      if (!cur_valid[i]) begin
        has_free  = 1'b1;
        free_slot = SLOT_W'(i);
      end
      // with every slot valid the ranks are a permutation, oldest is the top rank
      if (cur_rank[i] == RANK_W'(LINES - 1)) begin
        lru_slot = SLOT_W'(i);
      end
    end
  end

  assign slot = hit ? hit_slot : (has_free ? free_slot : lru_slot);

  // fields of the chosen slot
  always_comb begin
    old_rank     = '0;
    victim_line  = '0;
    victim_valid = 1'b0;
    for (int i = 0; i < LINES; i++) begin
      if (SLOT_W'(i) == slot) begin
        old_rank     = cur_rank[i];
        victim_line  = cur_line[i];
        victim_valid = cur_valid[i];
      end
    end
  end

  // rank aging and slot refill
  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      if (SLOT_W'(i) == slot) begin
        new_valid[i] = 1'b1;
        new_line[i]  = req_line;
        new_rank[i]  = '0;
      end else begin
        new_valid[i] = cur_valid[i];
        new_line[i]  = cur_line[i];
        if (cur_valid[i] && (!hit || (cur_rank[i] < old_rank))) begin
          new_rank[i] = cur_rank[i] + RANK_W'(1);
        end else begin
          new_rank[i] = cur_rank[i];
        end
      end
    end
  end

  assign res.hit         = hit;
  assign res.writeback   = !hit && victim_valid;
  assign res.slot        = slot;
  assign res.victim_line = victim_line;

endmodule
